FILE: sv/dht_pkg.sv
`default_nettype none
package dht_pkg;
  localparam int ID_W = 24;
  localparam int HEAD_W = 64;
  localparam int TAIL_W = 16;
  localparam int CNT_W = 11;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_UPSERT = 2'd1;
  localparam logic [1:0] CMD_BY_NAME = 2'd2;
  localparam logic [1:0] CMD_BY_ID = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Configuration register addresses.
  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;

  localparam logic [31:0] DJB_SEED = 32'd5381;
  localparam logic [31:0] ID_MULT = 32'd2654435761;
  localparam logic [CNT_W-1:0] MAX_RESET = 11'd716;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // latch input item, start key build
    logic key_step;   // one normalizer character step
    logic id_start;   // load id probe pointer
    logic id_rd;      // issue id table read
    logic id_adv;     // advance id probe
    logic nm_start;
    logic nm_rd;
    logic nm_adv;
    logic commit;     // write tables
    logic finish;     // build result
  } dht_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic key_done;
    logic klen_zero;
    logic id_zero;
    logic id_hit;     // slot matches or empty
    logic id_empty;
    logic id_wrap;    // all slots probed
    logic nm_hit;
    logic nm_empty;
    logic nm_wrap;
    logic cnt_full;
  } dht_sts_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction
endpackage
`default_nettype wire

FILE: sv/dht_if.sv
`default_nettype none
interface dht_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [23:0] subscriber_id;
  logic [63:0] name_head;
  logic [15:0] name_tail;
  modport source(output valid, cmd, subscriber_id, name_head, name_tail, input ready);
  modport sink(input valid, cmd, subscriber_id, name_head, name_tail, output ready);
endinterface

interface dht_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [23:0] found_id;
  logic [63:0] found_name_head;
  logic [15:0] found_name_tail;
  modport source(output valid, status, found_id, found_name_head, found_name_tail,
                 input ready);
  modport sink(input valid, status, found_id, found_name_head, found_name_tail,
               output ready);
endinterface
`default_nettype wire

FILE: sv/dht_datapath.sv
`default_nettype none
module dht_datapath #(
  parameter int TABLE_SLOTS = 1024,
  parameter int NAME_CHARS = 10
) (
  input  wire logic clk,
  input  wire dht_pkg::dht_cmd_t cmd_i,
  output dht_pkg::dht_sts_t sts,
  input  wire logic clr_en,
  input  wire logic [$clog2(TABLE_SLOTS)-1:0] clr_addr,
  input  wire logic [1:0] in_cmd,
  input  wire logic [23:0] in_id,
  input  wire logic [63:0] in_head,
  input  wire logic [15:0] in_tail,
  input  wire logic [dht_pkg::CNT_W-1:0] entry_count,
  input  wire logic [dht_pkg::CNT_W-1:0] max_entries,
  output logic [1:0] res_cmd,
  output logic [23:0] res_id,
  output logic [63:0] res_head,
  output logic [15:0] res_tail
);
  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int PW = AW + 1;
  localparam int NW = $clog2(11);

  logic [23:0] id_key_mem [TABLE_SLOTS];
  logic [63:0] id_head_mem [TABLE_SLOTS];
  logic [15:0] id_tail_mem [TABLE_SLOTS];
  logic [63:0] nm_head_mem [TABLE_SLOTS];
  logic [15:0] nm_tail_mem [TABLE_SLOTS];
  logic [23:0] nm_id_mem [TABLE_SLOTS];

  logic [1:0] cmd_r;
  logic [23:0] id_r;
  logic [79:0] raw;
  logic [NW-1:0] pos;
  logic [1:0] phase;   // 0 skip lead, 1 copy, 2 done
  logic [79:0] key;
  logic [NW-1:0] klen;
  logic [NW-1:0] ktrim;  // length up to last non-blank
  logic [31:0] hsh;
  logic [31:0] hsh_trim;
  logic [31:0] id_prod;
  logic [AW-1:0] id_ptr, nm_ptr;
  logic [PW-1:0] id_cnt, nm_cnt;
  logic [23:0] rd_id_key;
  logic [63:0] rd_id_head;
  logic [15:0] rd_id_tail;
  logic [63:0] rd_nm_head;
  logic [15:0] rd_nm_tail;
  logic [23:0] rd_nm_id;
  logic [7:0] ch, chu;
  logic end_of_raw;

  assign end_of_raw = (32'(pos) >= NAME_CHARS) || (pos >= NW'(10));
  assign ch = raw[79 - 8*pos -: 8];
  assign chu = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;

  always_ff @(posedge clk) begin
    // The latched number settles the product during the key walk.
    id_prod <= id_r * dht_pkg::ID_MULT;
    if (cmd_i.load) begin
      cmd_r <= in_cmd;
      id_r <= in_id;
      raw <= {in_head, in_tail};
      pos <= '0;
      phase <= 2'd0;
      key <= '0;
      klen <= '0;
      ktrim <= '0;
      hsh <= dht_pkg::DJB_SEED;
      hsh_trim <= dht_pkg::DJB_SEED;
    end else if (cmd_i.key_step && phase != 2'd2) begin
      if (end_of_raw || ch == 8'h00) begin
        phase <= 2'd2;
      end else if (phase == 2'd0 && dht_pkg::is_blank(ch)) begin
        pos <= pos + NW'(1);
      end else if (ch == 8'h2D || ch == 8'h2F) begin
        phase <= 2'd2;
      end else begin
        // Hash of the trimmed key is the hash at the last non-blank char.
        phase <= 2'd1;
        key[79 - 8*klen -: 8] <= chu;
        klen <= klen + NW'(1);
        hsh <= hsh * 32'd33 + 32'(chu);
        if (!dht_pkg::is_blank(chu)) begin
          ktrim <= klen + NW'(1);
          hsh_trim <= hsh * 32'd33 + 32'(chu);
        end
        pos <= pos + NW'(1);
      end
    end
  end

  logic [79:0] kmask;
  logic [79:0] key_t;
  always_comb begin
    for (int i = 0; i < 10; i++)
      kmask[79-8*i -: 8] = (i < 32'(ktrim)) ? 8'hFF : 8'h00;
    key_t = key & kmask;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.id_start) begin
      id_ptr <= id_prod[AW-1:0];
      id_cnt <= '0;
    end else if (cmd_i.id_adv) begin
      id_ptr <= id_ptr + AW'(1);
      id_cnt <= id_cnt + PW'(1);
    end
    if (cmd_i.nm_start) begin
      nm_ptr <= hsh_trim[AW-1:0];
      nm_cnt <= '0;
    end else if (cmd_i.nm_adv) begin
      nm_ptr <= nm_ptr + AW'(1);
      nm_cnt <= nm_cnt + PW'(1);
    end
  end

  logic id_wr_key, nm_wr_key, nm_wr_id;
  assign id_wr_key = cmd_i.commit && rd_id_key == '0;
  assign nm_wr_key = cmd_i.commit && rd_nm_head == '0;
  assign nm_wr_id = nm_wr_key || (cmd_i.commit && cmd_r == dht_pkg::CMD_UPSERT);

  always_ff @(posedge clk) begin
    if (cmd_i.id_rd) begin
      rd_id_key <= id_key_mem[id_ptr];
      rd_id_head <= id_head_mem[id_ptr];
      rd_id_tail <= id_tail_mem[id_ptr];
    end
    if (cmd_i.nm_rd) begin
      rd_nm_head <= nm_head_mem[nm_ptr];
      rd_nm_tail <= nm_tail_mem[nm_ptr];
      rd_nm_id <= nm_id_mem[nm_ptr];
    end
    // The clearing pass after reset empties one slot of each table a cycle.
    if (clr_en) begin
      id_key_mem[clr_addr] <= '0;
      nm_head_mem[clr_addr] <= '0;
    end
    if (id_wr_key) id_key_mem[id_ptr] <= id_r;
    if (cmd_i.commit) begin
      id_head_mem[id_ptr] <= key_t[79:16];
      id_tail_mem[id_ptr] <= key_t[15:0];
    end
    if (nm_wr_key) begin
      nm_head_mem[nm_ptr] <= key_t[79:16];
      nm_tail_mem[nm_ptr] <= key_t[15:0];
    end
    if (nm_wr_id) nm_id_mem[nm_ptr] <= id_r;
  end

  assign sts.key_done = (phase == 2'd2);
  assign sts.klen_zero = (ktrim == '0);
  assign sts.id_zero = (id_r == '0);
  assign sts.id_empty = (rd_id_key == '0);
  assign sts.id_hit = (rd_id_key == '0) || (rd_id_key == id_r);
  assign sts.id_wrap = (id_cnt == PW'(TABLE_SLOTS - 1));
  assign sts.nm_empty = (rd_nm_head == '0);
  assign sts.nm_hit = (rd_nm_head == '0) ||
                      (rd_nm_head == key_t[79:16] && rd_nm_tail == key_t[15:0]);
  assign sts.nm_wrap = (nm_cnt == PW'(TABLE_SLOTS - 1));
  assign sts.cnt_full = (entry_count >= max_entries);

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      res_cmd <= cmd_r;
      res_id <= rd_nm_id;
      for (int i = 0; i < 8; i++)
        res_head[8*i +: 8] <= (rd_id_head[8*i +: 8] == 8'h00) ? dht_pkg::CH_SPACE
                                                              : rd_id_head[8*i +: 8];
      for (int i = 0; i < 2; i++)
        res_tail[8*i +: 8] <= (rd_id_tail[8*i +: 8] == 8'h00) ? dht_pkg::CH_SPACE
                                                              : rd_id_tail[8*i +: 8];
    end
  end
endmodule
`default_nettype wire

FILE: sv/dht_ctrl.sv
`default_nettype none
module dht_ctrl #(
  parameter int TABLE_SLOTS = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic [1:0] in_cmd,
  input  wire dht_pkg::dht_sts_t sts,
  output dht_pkg::dht_cmd_t cmd_o,
  output logic busy,
  output logic res_load,
  output logic [1:0] res_status,
  output logic res_found,
  output logic cnt_inc
);
  typedef enum logic [3:0] {
    S_IDLE, S_KEY, S_HASH, S_IDRD, S_IDCHK, S_NMRD, S_NMCHK, S_COMMIT, S_DONE
  } state_t;
  state_t state;
  logic [1:0] c;
  logic [1:0] st;
  logic fnd;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_fire;
    cmd_o.key_step = (state == S_KEY);
    cmd_o.id_start = (state == S_HASH);
    cmd_o.nm_start = (state == S_HASH);
    cmd_o.id_rd = (state == S_IDRD);
    cmd_o.nm_rd = (state == S_NMRD);
    cmd_o.id_adv = (state == S_IDCHK) && !sts.id_hit && !sts.id_wrap;
    cmd_o.nm_adv = (state == S_NMCHK) && !sts.nm_hit && !sts.nm_wrap;
    cmd_o.commit = (state == S_COMMIT);
    cmd_o.finish = (state == S_DONE);
  end

  assign busy = (state != S_IDLE);
  assign res_status = st;
  assign res_found = fnd;
  assign res_load = (state == S_DONE);
  assign cnt_inc = (state == S_COMMIT) && sts.id_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      c <= '0;
      st <= '0;
      fnd <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) begin
          c <= in_cmd;
          st <= dht_pkg::ST_OK;
          fnd <= 1'b0;
          state <= S_KEY;
        end
        S_KEY: if (sts.key_done) state <= S_HASH;
        S_HASH: begin
          // Hash product settled during key build.
          if (c == dht_pkg::CMD_BY_ID) begin
            if (sts.id_zero) begin
              st <= dht_pkg::ST_INVALID;
              state <= S_DONE;
            end else state <= S_IDRD;
          end else if (c == dht_pkg::CMD_BY_NAME) begin
            if (sts.klen_zero) begin
              st <= dht_pkg::ST_INVALID;
              state <= S_DONE;
            end else state <= S_NMRD;
          end else if (sts.id_zero || sts.klen_zero) begin
            st <= dht_pkg::ST_INVALID;
            state <= S_DONE;
          end else state <= S_IDRD;
        end
        S_IDRD: state <= S_IDCHK;
        S_IDCHK: begin
          if (sts.id_hit) begin
            if (c == dht_pkg::CMD_BY_ID) begin
              if (sts.id_empty) st <= dht_pkg::ST_MISS;
              else fnd <= 1'b1;
              state <= S_DONE;
            end else if (sts.id_empty && sts.cnt_full) begin
              st <= dht_pkg::ST_FULL;
              state <= S_DONE;
            end else state <= S_NMRD;
          end else if (sts.id_wrap) begin
            st <= (c == dht_pkg::CMD_BY_ID) ? dht_pkg::ST_MISS : dht_pkg::ST_FULL;
            state <= S_DONE;
          end else state <= S_IDRD;
        end
        S_NMRD: state <= S_NMCHK;
        S_NMCHK: begin
          if (sts.nm_hit) begin
            if (c == dht_pkg::CMD_BY_NAME) begin
              if (sts.nm_empty) st <= dht_pkg::ST_MISS;
              else fnd <= 1'b1;
              state <= S_DONE;
            end else state <= S_COMMIT;
          end else if (sts.nm_wrap) begin
            st <= (c == dht_pkg::CMD_BY_NAME) ? dht_pkg::ST_MISS : dht_pkg::ST_FULL;
            state <= S_DONE;
          end else state <= S_NMRD;
        end
        S_COMMIT: state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/dual_hash_id_callsign_table_unit.sv
`default_nettype none
// From the accepting edge, the normalizer walks the raw name (one raw character a cycle and
// a closing step), then the probes run over the id table, the name table or both, each with
// a registered slot read, and an insert or upsert adds a table write before the result is
// valid. One transaction at a time: the next is accepted once the result has been taken.
// Reset clears entry_count, max_entries (716) and control state at once; a clearing pass
// over all TABLE_SLOTS slots then clears the keys.
module dual_hash_id_callsign_table_unit #(
  parameter int TABLE_SLOTS = 1024,
  parameter int NAME_CHARS = 10
) (
  input  wire logic clk,
  input  wire logic rst,
  dht_in_if.sink    in_ch,
  dht_out_if.source out_ch,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int AW = $clog2(TABLE_SLOTS);

  logic [dht_pkg::CNT_W-1:0] max_entries;
  logic [dht_pkg::CNT_W-1:0] entry_count;
  dht_pkg::dht_cmd_t cmd_w;
  dht_pkg::dht_sts_t sts;
  logic busy, res_load, res_found, cnt_inc;
  logic [1:0] res_status;
  logic [1:0] res_cmd;
  logic [23:0] res_id;
  logic [63:0] res_head;
  logic [15:0] res_tail;
  logic in_fire;
  // Clearing pass: the datapath zeroes the key words of one slot a cycle.
  logic clearing;
  logic [AW:0] clr_cnt;
  logic pend;
  logic [1:0] pend_status;
  logic pend_found;

  assign pready = 1'b1;
  assign prdata = (paddr == dht_pkg::REG_MAX_ENTRIES) ? 32'(max_entries) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) max_entries <= dht_pkg::MAX_RESET;
    else if (psel && penable && pwrite && paddr == dht_pkg::REG_MAX_ENTRIES)
      max_entries <= pwdata[dht_pkg::CNT_W-1:0];
  end

  // A result waits in out_ch until taken; the next item enters when it is gone.
  assign in_ch.ready = !busy && !pend && !out_ch.valid && !clearing;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (AW+1)'(TABLE_SLOTS - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) entry_count <= '0;
    else if (cnt_inc) entry_count <= entry_count + 1'b1;
  end

  dht_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
    .clk, .rst, .in_fire, .in_cmd(in_ch.cmd), .sts, .cmd_o(cmd_w), .busy,
    .res_load, .res_status, .res_found, .cnt_inc
  );

  dht_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .NAME_CHARS(NAME_CHARS)) u_dp (
    .clk, .cmd_i(cmd_w), .sts, .clr_en(clearing), .clr_addr(clr_cnt[AW-1:0]),
    .in_cmd(in_ch.cmd), .in_id(in_ch.subscriber_id),
    .in_head(in_ch.name_head), .in_tail(in_ch.name_tail), .entry_count,
    .max_entries, .res_cmd, .res_id, .res_head, .res_tail
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      pend <= res_load;
      if (res_load) begin
        pend_status <= res_status;
        pend_found <= res_found;
      end
      if (pend) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  assign out_ch.status = pend_status;
  assign out_ch.found_id = (pend_found && res_cmd == dht_pkg::CMD_BY_NAME) ? res_id : '0;
  assign out_ch.found_name_head = (pend_found && res_cmd == dht_pkg::CMD_BY_ID) ? res_head
                                                                               : '0;
  assign out_ch.found_name_tail = (pend_found && res_cmd == dht_pkg::CMD_BY_ID) ? res_tail
                                                                               : '0;
endmodule
`default_nettype wire
